// File: hdl/fba_pkg.sv
// Shared types and codes for the frame bitmap allocator.
package fba_pkg;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Port widths fixed by the interface
  localparam int unsigned FRAME_W = 12;
  localparam int unsigned COUNT_W = 13;

  // Frame count after reset
  localparam logic [COUNT_W-1:0] FC_RESET = 13'd4096;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SETW,
    S_FREE_WR,
    S_DONE
  } state_e;

  // One result beat from the sequencer
  typedef struct packed {
    logic [FRAME_W-1:0] new_frame;
    logic               present_bit;
    logic               rw_bit;
    logic               user_bit;
    logic [1:0]         status;
  } res_t;

endpackage

// File: hdl/frame_bitmap_allocator.sv
// Top level of the first-fit bitmap frame allocator.
//
// One bit per frame, set while the frame is in use. An input beat on the
// in_ channel either allocates (req_type 0) or frees (req_type 1) a frame;
// each input beat yields exactly one result beat on the out_ channel.
// An allocation with current_frame 0 takes the lowest clear frame below
// frame_count (clamped to MAX_FRAMES); status reports done, no change, or
// out of frames. WORD_BITS must be a power of two.
// A request that needs no memory access goes from accept straight to the
// result register; a free reads its word, then writes it back. An allocation scans
// one bitmap word per cycle through the single memory read port and the
// shared word scan unit, then sets the chosen bit in the hit word; a scan
// that misses stops at the last word inside the limit. One item is in
// work at a time; in_stall_o is high while it is. The result register lets
// the next item be accepted while a result waits; a stalled result only
// holds back the finish of the following one.
// After reset the bitmap is cleared one word a cycle with in_stall_o high;
// frame_count resets to 4096 and may be written at any time the block is idle.
module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 4096,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [FRAME_W-1:0] current_frame_i,
  input  logic               kernel_only_i,
  input  logic               writeable_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FRAME_W-1:0] new_frame_o,
  output logic               present_bit_o,
  output logic               rw_bit_o,
  output logic               user_bit_o,
  output logic [1:0]         status_o
);

  localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned LIM_W     = $clog2(MAX_FRAMES + 1);

  logic [COUNT_W-1:0]   frame_count_q;
  logic [LIM_W-1:0]     limit;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 res_valid;
  res_t                 res;
  logic                 res_take;
  logic                 out_valid_q;
  res_t                 out_q;

  // Hold the frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FC_RESET;
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_wdata_i;
    end
  end

  // Clamp the scan limit to the map size
  assign limit = (32'(frame_count_q) > MAX_FRAMES) ? LIM_W'(MAX_FRAMES)
                                                   : LIM_W'(frame_count_q);

  fba_map_mem #(
    .DEPTH  (MAP_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  fba_seq #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS),
    .MAP_WORDS  (MAP_WORDS),
    .ADDR_W     (ADDR_W),
    .BIT_W      (BIT_W),
    .LIM_W      (LIM_W)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .limit_i         (limit),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .current_frame_i (current_frame_i),
    .kernel_only_i   (kernel_only_i),
    .writeable_i     (writeable_i),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .res_take_i      (res_take)
  );

  // Result register takes a beat when empty or being drained
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_frame_o   = out_q.new_frame;
  assign present_bit_o = out_q.present_bit;
  assign rw_bit_o      = out_q.rw_bit;
  assign user_bit_o    = out_q.user_bit;
  assign status_o      = out_q.status;

  // An accepted beat makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block idle right after accepting a beat");

  // A finished result waits in the sequencer until the result register takes it
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_take) |=> res_valid)
    else $error("result dropped while result register was full");

  // Present flag only comes with a completed allocation
  a_present_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && present_bit_o) |-> (status_o == ST_DONE))
    else $error("present bit set on a result that is not done");

  // Status is always one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_DONE) || (status_o == ST_NOCHANGE) ||
                     (status_o == ST_FULL)))
    else $error("undefined status code on result");

endmodule

// File: hdl/fba_map_mem.sv
// Bitmap word memory: one write port, one registered read port.
module fba_map_mem #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/fba_word_scan.sv
// Shared find-first-clear unit over one bitmap word, masked at the frame limit.
module fba_word_scan #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned BIT_W     = 5
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic                 is_last_i,
  input  logic [BIT_W-1:0]     last_bit_i,
  output logic                 found_o,
  output logic [BIT_W-1:0]     bit_o
);

  // Lowest clear bit wins; in the last word only bits up to the limit count
  always_comb begin
    found_o = 1'b0;
    bit_o   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word_i[b] && (!is_last_i || (BIT_W'(b) <= last_bit_i))) begin
        found_o = 1'b1;
        bit_o   = BIT_W'(b);
      end
    end
  end

endmodule

// File: hdl/fba_seq.sv
// Sequencer: clearing pass, first-fit word scan, bit set and bit clear.
module fba_seq import fba_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 4096,
  parameter int unsigned WORD_BITS  = 32,
  parameter int unsigned MAP_WORDS  = 128,
  parameter int unsigned ADDR_W     = 7,
  parameter int unsigned BIT_W      = 5,
  parameter int unsigned LIM_W      = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LIM_W-1:0]     limit_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [FRAME_W-1:0]   current_frame_i,
  input  logic                 kernel_only_i,
  input  logic                 writeable_i,
  output logic                 rd_en_o,
  output logic [ADDR_W-1:0]    rd_addr_o,
  input  logic [WORD_BITS-1:0] rd_data_i,
  output logic                 wr_en_o,
  output logic [ADDR_W-1:0]    wr_addr_o,
  output logic [WORD_BITS-1:0] wr_data_o,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  logic                 res_take_i
);

  state_e state_q, state_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic [ADDR_W-1:0]    issue_q, issue_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]    rd_word_q, rd_word_d;
  logic [ADDR_W-1:0]    hit_word_q, hit_word_d;
  logic [BIT_W-1:0]     hit_bit_q, hit_bit_d;
  logic [WORD_BITS-1:0] hit_data_q, hit_data_d;
  logic                 kern_q, kern_d;
  logic                 wr_q, wr_d;
  res_t                 res_q, res_d;

  logic [LIM_W-1:0]  lim_m1;
  logic [ADDR_W-1:0] last_word;
  logic [BIT_W-1:0]  last_bit;
  logic              is_last;
  logic              found;
  logic [BIT_W-1:0]  found_bit;
  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] cur_word;
  logic [BIT_W-1:0]  cur_bit;

  // Last frame inside the limit, split into word and bit
  assign lim_m1    = limit_i - LIM_W'(1);
  assign last_word = ADDR_W'(lim_m1 >> BIT_W);
  assign last_bit  = lim_m1[BIT_W-1:0];
  assign is_last   = (rd_word_q == last_word);

  // Frame of the request, split into word and bit
  assign in_range = (32'(current_frame_i) < MAX_FRAMES);
  assign cur_word = ADDR_W'(current_frame_i >> BIT_W);
  assign cur_bit  = current_frame_i[BIT_W-1:0];

  assign accept = in_valid_i && (state_q == S_IDLE);

  fba_word_scan #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_scan (
    .word_i     (rd_data_i),
    .is_last_i  (is_last),
    .last_bit_i (last_bit),
    .found_o    (found),
    .bit_o      (found_bit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == ADDR_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_ALLOC) begin
            if ((current_frame_i != '0) || (limit_i == '0)) begin
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            if ((current_frame_i != '0) && in_range) begin
              state_d = S_FREE_WR;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          if (found) begin
            state_d = S_SETW;
          end else if (is_last) begin
            state_d = S_DONE;
          end
        end
      end
      S_SETW:    state_d = S_DONE;
      S_FREE_WR: state_d = S_DONE;
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_d      = clr_q;
    issue_d    = issue_q;
    rd_vld_d   = 1'b0;
    rd_word_d  = rd_word_q;
    hit_word_d = hit_word_q;
    hit_bit_d  = hit_bit_q;
    hit_data_d = hit_data_q;
    kern_d     = kern_q;
    wr_d       = wr_q;
    res_d      = res_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = issue_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = hit_word_q;
    wr_data_o  = '0;
    unique case (state_q)
      S_CLEAR: begin
        // Zero one word a cycle
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
      end
      S_IDLE: begin
        res_d   = '0;
        issue_d = '0;
        if (accept) begin
          kern_d    = kernel_only_i;
          wr_d      = writeable_i;
          hit_word_d = cur_word;
          hit_bit_d  = cur_bit;
          if (req_type_i == REQ_ALLOC) begin
            if (current_frame_i != '0) begin
              res_d.new_frame = current_frame_i;
              res_d.status    = ST_NOCHANGE;
            end else if (limit_i == '0) begin
              res_d.status = ST_FULL;
            end
          end else begin
            if (current_frame_i == '0) begin
              res_d.status = ST_NOCHANGE;
            end else if (in_range) begin
              // Fetch the word that holds the frame
              rd_en_o   = 1'b1;
              rd_addr_o = cur_word;
            end
          end
        end
      end
      S_SCAN: begin
        // Issue the next word while checking the one returned
        if (issue_q <= last_word) begin
          rd_en_o  = 1'b1;
          issue_d  = issue_q + ADDR_W'(1);
          rd_vld_d = 1'b1;
          rd_word_d = issue_q;
        end
        if (rd_vld_q) begin
          if (found) begin
            hit_word_d = rd_word_q;
            hit_bit_d  = found_bit;
            hit_data_d = rd_data_i;
          end else if (is_last) begin
            res_d.status = ST_FULL;
          end
        end
      end
      S_SETW: begin
        // Mark the chosen frame used
        wr_en_o   = 1'b1;
        wr_data_o = hit_data_q | (WORD_BITS'(1) << hit_bit_q);
        res_d.new_frame   = FRAME_W'({hit_word_q, hit_bit_q});
        res_d.present_bit = 1'b1;
        res_d.rw_bit      = wr_q;
        res_d.user_bit    = !kern_q;
        res_d.status      = ST_DONE;
      end
      S_FREE_WR: begin
        // Clear the freed frame in the fetched word
        wr_en_o   = 1'b1;
        wr_data_o = rd_data_i & ~(WORD_BITS'(1) << hit_bit_q);
        res_d     = '0;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_word_q  <= rd_word_d;
    hit_word_q <= hit_word_d;
    hit_bit_q  <= hit_bit_d;
    hit_data_q <= hit_data_d;
    kern_q     <= kern_d;
    wr_q       <= wr_d;
    res_q      <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// File: dv/frame_bitmap_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap frame allocator.
module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  localparam int unsigned MAP_FRAMES   = 4096;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned LIMIT_CYCLES = 1000000;

  // One request beat as queued for the driver
  typedef struct packed {
    logic               req;
    logic [FRAME_W-1:0] frame;
    logic               kernel;
    logic               wr;
  } frame_req_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               req_type_i      = REQ_ALLOC;
  logic [FRAME_W-1:0] current_frame_i = '0;
  logic               kernel_only_i   = 1'b0;
  logic               writeable_i     = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [FRAME_W-1:0] new_frame_o;
  logic               present_bit_o;
  logic               rw_bit_o;
  logic               user_bit_o;
  logic [1:0]         status_o;

  // Shadow of the frame bitmap and the frame count register
  bit                 frame_used [MAP_FRAMES];
  logic [COUNT_W-1:0] fc_model = FC_RESET;

  frame_req_t  pending_reqs[$];
  res_t        expected_results[$];
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles    = 0;
  bit          pressure_on    = 1'b0;

  frame_bitmap_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .current_frame_i (current_frame_i),
    .kernel_only_i   (kernel_only_i),
    .writeable_i     (writeable_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .new_frame_o     (new_frame_o),
    .present_bit_o   (present_bit_o),
    .rw_bit_o        (rw_bit_o),
    .user_bit_o      (user_bit_o),
    .status_o        (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one request to the shadow bitmap and return the result it yields
  function automatic res_t predict_map_update(input logic req, input logic [FRAME_W-1:0] frame,
                                              input logic kernel, input logic wr);
    res_t        r;
    int unsigned lim;
    int unsigned f;
    r = '0;
    if (req == REQ_ALLOC) begin
      if (frame != '0) begin
        r.new_frame = frame;
        r.status    = ST_NOCHANGE;
      end else begin
        lim = (32'(fc_model) > MAP_FRAMES) ? MAP_FRAMES : 32'(fc_model);
        f = 0;
        while (f < lim && frame_used[f]) f++;
        if (f < lim) begin
          frame_used[f] = 1'b1;
          r.new_frame   = f[FRAME_W-1:0];
          r.present_bit = 1'b1;
          r.rw_bit      = wr;
          r.user_bit    = ~kernel;
          r.status      = ST_DONE;
        end else begin
          r.status = ST_FULL;
        end
      end
    end else begin
      if (frame == '0) begin
        r.status = ST_NOCHANGE;
      end else begin
        frame_used[frame] = 1'b0;
        r.status = ST_DONE;
      end
    end
    return r;
  endfunction

  function automatic void queue_req(input logic req, input logic [FRAME_W-1:0] frame,
                                    input logic kernel, input logic wr);
    frame_req_t item;
    item.req    = req;
    item.frame  = frame;
    item.kernel = kernel;
    item.wr     = wr;
    pending_reqs.push_back(item);
  endfunction

  // Mostly well-formed traffic: fresh allocations and frees near the live range
  task automatic queue_random_reqs(input int unsigned n);
    int unsigned sel;
    int unsigned lim;
    int unsigned span;
    logic        kern;
    logic        wrb;
    lim  = (32'(fc_model) > MAP_FRAMES) ? MAP_FRAMES : 32'(fc_model);
    span = (lim == 0) ? 8 : ((lim + 2 > 4095) ? 4095 : lim + 2);
    repeat (n) begin
      sel  = $urandom_range(99);
      kern = 1'($urandom_range(1));
      wrb  = 1'($urandom_range(1));
      if (sel < 55)
        queue_req(REQ_ALLOC, '0, kern, wrb);
      else if (sel < 63)
        queue_req(REQ_ALLOC, FRAME_W'($urandom_range(4095, 1)), kern, wrb);
      else if (sel < 88)
        queue_req(REQ_FREE, FRAME_W'($urandom_range(span, 1)), kern, wrb);
      else if (sel < 93)
        queue_req(REQ_FREE, '0, kern, wrb);
      else
        queue_req(REQ_FREE, FRAME_W'($urandom_range(4095)), kern, wrb);
    end
  endtask

  // Write the frame count register; call only while the block is idle
  task automatic write_frame_count(input logic [COUNT_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    fc_model = value;
  endtask

  // Wait until every queued beat has gone in and every result has come out
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] fc, input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned n);
    write_frame_count(fc);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_reqs(n);
    wait_drained();
  endtask

  // Drive request beats; predict each one as it is accepted
  always @(posedge clk_i) begin : req_driver
    frame_req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(predict_map_update(req_type_i, current_frame_i,
                                                      kernel_only_i, writeable_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_type_i      <= nxt.req;
          current_frame_i <= nxt.frame;
          kernel_only_i   <= nxt.kernel;
          writeable_i     <= nxt.wr;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      if (mismatch_cnt < 10)
        $display("result mismatch on %s: expected %0d, got %0d", field, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Count the cycles of the long receiver hold-off
  always @(posedge clk_i) begin : hold_counter
    if (rst_ni && pressure_on && hold_cycles < HOLD_LEN)
      hold_cycles <= hold_cycles + 1;
  end

  // Check result beats against the oldest prediction; stall at random or hold off
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result beat: new_frame %0d status %0d", new_frame_o, status_o);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("new_frame", 32'(want.new_frame), 32'(new_frame_o));
          check_field("present_bit", 32'(want.present_bit), 32'(present_bit_o));
          check_field("rw_bit", 32'(want.rw_bit), 32'(rw_bit_o));
          check_field("user_bit", 32'(want.user_bit), 32'(user_bit_o));
          check_field("status", 32'(want.status), 32'(status_o));
        end
      end
      if (pressure_on && hold_cycles < HOLD_LEN) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Give up on a hung block
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Let the bitmap clearing pass finish
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);

    // Directed: frame zero, already mapped, full, nothing to free, double free
    write_frame_count(13'd5);
    queue_req(REQ_ALLOC, '0, 1'b1, 1'b0);
    queue_req(REQ_ALLOC, '0, 1'b0, 1'b1);
    queue_req(REQ_ALLOC, 12'd4095, 1'b1, 1'b1);
    queue_req(REQ_ALLOC, 12'd1, 1'b0, 1'b0);
    queue_req(REQ_ALLOC, '0, 1'b1, 1'b1);
    queue_req(REQ_ALLOC, '0, 1'b0, 1'b0);
    queue_req(REQ_ALLOC, '0, 1'b1, 1'b0);
    queue_req(REQ_ALLOC, '0, 1'b0, 1'b1);
    queue_req(REQ_FREE, '0, 1'b1, 1'b1);
    queue_req(REQ_FREE, 12'd4095, 1'b0, 1'b0);
    queue_req(REQ_FREE, 12'd3, 1'b0, 1'b0);
    queue_req(REQ_FREE, 12'd3, 1'b1, 1'b1);
    queue_req(REQ_ALLOC, '0, 1'b0, 1'b0);
    queue_req(REQ_ALLOC, '0, 1'b1, 1'b1);
    queue_req(REQ_FREE, 12'd2, 1'b0, 1'b1);
    queue_req(REQ_ALLOC, '0, 1'b1, 1'b1);
    wait_drained();

    // Directed: empty range, then a count above the map size
    write_frame_count(13'd0);
    queue_req(REQ_ALLOC, '0, 1'b0, 1'b1);
    queue_req(REQ_FREE, 12'd1, 1'b0, 1'b0);
    wait_drained();
    write_frame_count(13'd8191);
    queue_req(REQ_ALLOC, '0, 1'b0, 1'b1);
    queue_req(REQ_ALLOC, '0, 1'b1, 1'b0);
    wait_drained();

    // Random phases over counts and idle patterns
    run_phase(13'd4096, 0, 0, 90);
    run_phase(13'd40, 68, 0, 110);
    run_phase(13'd64, 0, 68, 110);
    run_phase(13'd1, 37, 37, 50);
    run_phase(COUNT_W'($urandom_range(200, 2)), 37, 37, 110);
    run_phase(COUNT_W'($urandom_range(8191, 4097)), 0, 0, 60);
    // Hold the result side off so the block backs up into its input
    pressure_on = 1'b1;
    run_phase(13'd33, 0, 0, 100);
    pressure_on = 1'b0;
    run_phase(13'd0, 68, 68, 30);
    run_phase(13'd96, 37, 37, 100);
    run_phase(13'd4096, 0, 0, 80);

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: frame_bitmap_allocator.f
hdl/fba_pkg.sv
hdl/fba_map_mem.sv
hdl/fba_word_scan.sv
hdl/fba_seq.sv
hdl/frame_bitmap_allocator.sv
dv/frame_bitmap_allocator_tb.sv
